### sv/psrs_pkg.sv
package psrs_pkg;

    localparam int PCT_WIDTH   = 7;
    localparam int CLS_WIDTH   = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int DATA_WIDTH  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [15:0] MIN_SAMPLES_RESET = 16'd20;
    localparam int          PCT_SCALE         = 100;

    typedef enum logic [CLS_WIDTH-1:0] {
        CLS_A     = 2'd0,
        CLS_B     = 2'd1,
        CLS_OTHER = 2'd2,
        CLS_NONE  = 2'd3
    } sample_class_t;

    typedef enum logic {
        REQ_SAMPLE     = 1'b0,
        REQ_WINDOW_END = 1'b1
    } req_type_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_SIZE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_SIZE      = 3'd5;

    typedef struct packed {
        logic                 done;
        logic [PCT_WIDTH-1:0] quotient;
    } div_res_t;

endpackage

### sv/psrs_divider.sv
module psrs_divider
    import psrs_pkg::*;
#(
    parameter int NUM_WIDTH = 24,
    parameter int DEN_WIDTH = 18
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [DEN_WIDTH-1:0] divisor,
    output div_res_t             res
);

    // Restoring division, one quotient bit per cycle. Quotient is known to
    // fit PCT_WIDTH bits (dividend < 2^PCT_WIDTH * divisor).
    localparam int SH_WIDTH = DEN_WIDTH + PCT_WIDTH - 1;
    localparam int RW       = (SH_WIDTH > NUM_WIDTH) ? SH_WIDTH : NUM_WIDTH;
    localparam int STEP_W   = $clog2(PCT_WIDTH);

    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        dsh_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [PCT_WIDTH-1:0] quot_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 ge;
    logic [RW-1:0]        diff;

    assign ge   = (rem_reg >= dsh_reg);
    assign diff = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(PCT_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(dividend);
            dsh_reg <= RW'(divisor) << (PCT_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff;
            end
            quot_reg <= {quot_reg[PCT_WIDTH-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = quot_reg;

endmodule

### sv/pc_sample_region_share_top.sv
// Sampling profiler histogram. Each sample transfer carries a program counter
// that, while enabled, is classed as region A, region B or other (pc - base,
// mod 2^32, below size; a zero base turns the region off, A wins over B) and
// counted with saturation. A window-end transfer totals the counts and, if the
// total is nonzero and at least min_samples, publishes three rounded
// percentages; counts are cleared either way. The three percentages go one
// after another through a single restoring divider that produces one quotient
// bit per cycle; each is a load of the divider, 7 quotient bits and a step to
// take the quotient. Results leave through an output register, so a sample may
// be taken while the previous result is being transferred. Config writes are
// always ready.
module pc_sample_region_share_top
    import psrs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_WIDTH-1:0]  s_axis_tdata,   // pc[31:0]
    input  logic                   s_axis_tuser,   // req_type[0]

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_class[1:0], share_a[8:2], share_b[15:9], share_other[22:16],
    // shares_valid[23], published[24], zero[31:25]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_WIDTH-1:0]  cfg_data
);

    localparam int TW   = COUNT_WIDTH + 2;
    localparam int NW   = COUNT_WIDTH + 8;
    localparam int CMPW = (TW > 16) ? TW : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_a_reg, cnt_a_next;
    logic [COUNT_WIDTH-1:0] cnt_b_reg, cnt_b_next;
    logic [COUNT_WIDTH-1:0] cnt_o_reg, cnt_o_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [1:0]             sel_reg, sel_next;
    logic [PCT_WIDTH-1:0]   pct_reg [3];
    logic [PCT_WIDTH-1:0]   pct_next [3];
    logic                   vflag_reg, vflag_next;
    logic                   pub_reg, pub_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                   enable_reg;
    logic [15:0]            min_samples_reg;
    logic [DATA_WIDTH-1:0]  a_base_reg, a_size_reg, b_base_reg, b_size_reg;

    logic                   accept;
    logic                   in_a, in_b;
    logic [DATA_WIDTH-1:0]  off_a, off_b;
    logic [COUNT_WIDTH-1:0] div_count;
    logic [NW-1:0]          dividend;
    logic                   div_start;
    div_res_t               div_res;

    function automatic logic [OUT_TDATA_W-1:0] pack_out(
        input sample_class_t        cls,
        input logic [PCT_WIDTH-1:0] sa,
        input logic [PCT_WIDTH-1:0] sb,
        input logic [PCT_WIDTH-1:0] so,
        input logic                 v,
        input logic                 p
    );
        logic [OUT_TDATA_W-1:0] w;
        w = '0;
        w[1:0]   = cls;
        w[8:2]   = sa;
        w[15:9]  = sb;
        w[22:16] = so;
        w[23]    = v;
        w[24]    = p;
        return w;
    endfunction

    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign off_a = s_axis_tdata - a_base_reg;
    assign off_b = s_axis_tdata - b_base_reg;
    assign in_a  = (a_base_reg != '0) && (off_a < a_size_reg);
    assign in_b  = (b_base_reg != '0) && (off_b < b_size_reg);

    // count * 100 + total / 2 as shifts and adds
    always_comb
    begin
        unique case (sel_reg)
            2'd0:    div_count = cnt_a_reg;
            2'd1:    div_count = cnt_b_reg;
            default: div_count = cnt_o_reg;
        endcase
    end

    assign dividend = (NW'(div_count) << 6) + (NW'(div_count) << 5)
                    + (NW'(div_count) << 2) + NW'(total_reg >> 1);
    assign div_start = (state_reg == ST_DIV_START);

    psrs_divider #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (total_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        cnt_o_next     = cnt_o_reg;
        total_next     = total_reg;
        sel_next       = sel_reg;
        pct_next       = pct_reg;
        vflag_next     = vflag_reg;
        pub_next       = pub_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!enable_reg)
                    begin
                        vflag_next     = 1'b0;
                        out_valid_next = 1'b1;
                        out_data_next  = pack_out(CLS_NONE, pct_reg[0], pct_reg[1],
                                                  pct_reg[2], 1'b0, 1'b0);
                    end
                    else if (s_axis_tuser == REQ_SAMPLE)
                    begin
                        out_valid_next = 1'b1;
                        if (in_a)
                        begin
                            if (cnt_a_reg != COUNT_MAX)
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            out_data_next = pack_out(CLS_A, pct_reg[0], pct_reg[1],
                                                     pct_reg[2], vflag_reg, 1'b0);
                        end
                        else if (in_b)
                        begin
                            if (cnt_b_reg != COUNT_MAX)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            out_data_next = pack_out(CLS_B, pct_reg[0], pct_reg[1],
                                                     pct_reg[2], vflag_reg, 1'b0);
                        end
                        else
                        begin
                            if (cnt_o_reg != COUNT_MAX)
                            begin
                                cnt_o_next = cnt_o_reg + 1'b1;
                            end
                            out_data_next = pack_out(CLS_OTHER, pct_reg[0], pct_reg[1],
                                                     pct_reg[2], vflag_reg, 1'b0);
                        end
                    end
                    else
                    begin
                        total_next = TW'(cnt_a_reg) + TW'(cnt_b_reg) + TW'(cnt_o_reg);
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                sel_next = 2'd0;
                if ((total_reg != '0) && (CMPW'(total_reg) >= CMPW'(min_samples_reg)))
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    pub_next   = 1'b0;
                    state_next = ST_FINISH;
                end
            end

            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    pct_next[sel_reg] = div_res.quotient;
                    if (sel_reg == 2'd2)
                    begin
                        vflag_next = 1'b1;
                        pub_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end

            ST_FINISH:
            begin
                // counts feed the divider, so they are cleared only here
                cnt_a_next     = '0;
                cnt_b_next     = '0;
                cnt_o_next     = '0;
                // output register was free or drained when the item was taken
                out_valid_next = 1'b1;
                out_data_next  = pack_out(CLS_NONE, pct_reg[0], pct_reg[1],
                                          pct_reg[2], vflag_reg, pub_reg);
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            cnt_o_reg     <= '0;
            total_reg     <= '0;
            sel_reg       <= 2'd0;
            pct_reg[0]    <= '0;
            pct_reg[1]    <= '0;
            pct_reg[2]    <= '0;
            vflag_reg     <= 1'b0;
            pub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            cnt_o_reg     <= cnt_o_next;
            total_reg     <= total_next;
            sel_reg       <= sel_next;
            pct_reg       <= pct_next;
            vflag_reg     <= vflag_next;
            pub_reg       <= pub_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            min_samples_reg <= MIN_SAMPLES_RESET;
            a_base_reg      <= '0;
            a_size_reg      <= '0;
            b_base_reg      <= '0;
            b_size_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:      enable_reg      <= cfg_data[0];
                CFG_MIN_SAMPLES: min_samples_reg <= cfg_data[15:0];
                CFG_A_BASE:      a_base_reg      <= cfg_data;
                CFG_A_SIZE:      a_size_reg      <= cfg_data;
                CFG_B_BASE:      b_base_reg      <= cfg_data;
                CFG_B_SIZE:      b_size_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

endmodule
